[sv/hbh_pkg.sv]
// Shared types and codes for the hop-by-hop prefix route walk.
// Holds the input and result beat structs, table records and state encoding.
// No dependencies.
package hbh_pkg;

  localparam logic [1:0] KIND_HOST  = 2'd0;
  localparam logic [1:0] KIND_ROUTE = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] ST_HOP     = 3'd0;
  localparam logic [2:0] ST_DEST    = 3'd1;
  localparam logic [2:0] ST_NET     = 3'd2;
  localparam logic [2:0] ST_NOROUTE = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_LIMIT   = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  host_index;
    logic [3:0]  entry_index;
    logic [4:0]  entry_count;
    logic [31:0] host_ip;
    logic [31:0] subnet_ip;
    logic [31:0] subnet_mask;
    logic [31:0] forward_ip;
    logic [31:0] origin_ip;
    logic [31:0] dest_ip;
  } in_item_t;

  typedef struct packed {
    logic [31:0] node_ip;
    logic [2:0]  node_host_index;
    logic [2:0]  status;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [4:0]  count;
  } host_rec_t;

  typedef struct packed {
    logic [31:0] subnet;
    logic [31:0] mask;
    logic [31:0] next_hop;
  } route_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HOP,
    S_HSCAN,
    S_RSCAN
  } fsm_t;

endpackage

[sv/hbh_host_table.sv]
// Host table: per-slot IP and entry count in a synchronous memory,
// plus per-slot valid bits cleared at reset. Depends on hbh_pkg.
module hbh_host_table #(
  parameter int NUM_HOSTS = 8,
  localparam int HW = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [HW-1:0]            wr_idx,
  input  hbh_pkg::host_rec_t       wr_rec,
  input  logic [HW-1:0]            rd_idx,
  output hbh_pkg::host_rec_t       rd_rec,
  output logic [NUM_HOSTS-1:0]     valid
);
  import hbh_pkg::*;

  host_rec_t             mem [NUM_HOSTS];
  host_rec_t             rd_rec_r;
  logic [NUM_HOSTS-1:0]  valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_rec;
    end
    rd_rec_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_idx] <= 1'b1;
    end
  end

  assign rd_rec = rd_rec_r;
  assign valid  = valid_r;

endmodule

[sv/hbh_route_table.sv]
// Route table: subnet, mask and next hop for every host entry in one
// synchronous memory with registered read. Depends on hbh_pkg.
module hbh_route_table #(
  parameter int NUM_HOSTS = 8,
  parameter int ENTRIES_PER_HOST = 16,
  localparam int RAW = (NUM_HOSTS * ENTRIES_PER_HOST > 1) ?
                       $clog2(NUM_HOSTS * ENTRIES_PER_HOST) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [RAW-1:0]    wr_addr,
  input  hbh_pkg::route_t   wr_data,
  input  logic [RAW-1:0]    rd_addr,
  output hbh_pkg::route_t   rd_data
);
  import hbh_pkg::*;

  route_t mem [NUM_HOSTS * ENTRIES_PER_HOST];
  route_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/hop_by_hop_prefix_route_walk_core.sv]
// Top level of the hop-by-hop prefix route walk: load decode, walk sequencer
// and result register. Depends on hbh_pkg, hbh_host_table, hbh_route_table.
//
// Usage: drive in_item and raise start; the beat is taken on a rising edge
// with start high and busy low. Host and route loads give no result. A query
// with nonzero source and destination walks hop by hop and
// gives one result per hop on out_item, marked by out_valid for one cycle;
// the final result carries last. The receiver cannot stall: results must be
// taken in the cycle they appear.
// Sequence: each hop has a decision state, a host scan of up to NUM_HOSTS
// slots through the host memory read port, and a route scan of the host's
// count entries through the route memory read port, one entry per cycle.
// A walk takes at most MAX_HOPS hops; busy stays high for the whole walk.
// Reset clears the sequencer, the result strobe and the host valid bits;
// table contents are left as they are and count only once loaded.
module hop_by_hop_prefix_route_walk_core #(
  parameter int NUM_HOSTS = 8,
  parameter int ENTRIES_PER_HOST = 16,
  parameter int MAX_HOPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hbh_pkg::in_item_t   in_item,
  output logic                out_valid,
  output hbh_pkg::out_item_t  out_item
);
  import hbh_pkg::*;

  localparam int HW  = (NUM_HOSTS > 1) ? $clog2(NUM_HOSTS) : 1;
  localparam int HCW = $clog2(NUM_HOSTS + 1);
  localparam int RAW = (NUM_HOSTS * ENTRIES_PER_HOST > 1) ?
                       $clog2(NUM_HOSTS * ENTRIES_PER_HOST) : 1;
  localparam int KW  = (MAX_HOPS > 1) ? $clog2(MAX_HOPS) : 1;

  fsm_t                 state_r, state_nxt;
  logic [31:0]          cur_r, cur_nxt;
  logic [31:0]          dst_r, dst_nxt;
  logic [KW-1:0]        hop_r, hop_nxt;
  logic [HCW-1:0]       hs_r, hs_nxt;
  logic                 hq_vld_r, hq_vld_nxt;
  logic [HW-1:0]        hq_tag_r, hq_tag_nxt;
  logic [HW-1:0]        h_r, h_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  logic [4:0]           ep_r, ep_nxt;
  logic                 rq_vld_r, rq_vld_nxt;
  logic [4:0]           rq_tag_r, rq_tag_nxt;
  logic                 best_vld_r, best_vld_nxt;
  logic [31:0]          best_mask_r, best_mask_nxt;
  logic [31:0]          best_next_r, best_next_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 accept;
  logic                 host_we;
  logic                 route_we;
  host_rec_t            host_wr;
  route_t               route_wr;
  logic [RAW-1:0]       route_waddr;
  logic [RAW-1:0]       route_raddr;
  host_rec_t            host_rd;
  route_t               route_rd;
  logic [NUM_HOSTS-1:0] host_valid;
  logic                 host_hit;
  logic                 host_end;
  logic                 better;
  logic                 fin_vld;
  logic [31:0]          fin_next;

  function automatic out_item_t mk_out(logic [31:0] ip, logic [2:0] slot,
                                       logic [2:0] st, logic lst);
    out_item_t o;
    o.node_ip         = ip;
    o.node_host_index = slot;
    o.status          = st;
    o.last            = lst;
    return o;
  endfunction

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign host_we  = accept && (in_item.kind == KIND_HOST) &&
                    (32'(in_item.host_index) < NUM_HOSTS);
  assign route_we = accept && (in_item.kind == KIND_ROUTE) &&
                    (32'(in_item.host_index) < NUM_HOSTS) &&
                    (32'(in_item.entry_index) < ENTRIES_PER_HOST);

  assign host_wr.ip    = in_item.host_ip;
  assign host_wr.count = (32'(in_item.entry_count) > ENTRIES_PER_HOST) ?
                         5'(ENTRIES_PER_HOST) : in_item.entry_count;

  assign route_wr.subnet   = in_item.subnet_ip;
  assign route_wr.mask     = in_item.subnet_mask;
  assign route_wr.next_hop = in_item.forward_ip;

  assign route_waddr = RAW'(32'(in_item.host_index) * ENTRIES_PER_HOST +
                            32'(in_item.entry_index));
  assign route_raddr = RAW'(32'(h_r) * ENTRIES_PER_HOST + 32'(ep_r));

  hbh_host_table #(
    .NUM_HOSTS (NUM_HOSTS)
  ) u_host (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (host_we),
    .wr_idx (HW'(in_item.host_index)),
    .wr_rec (host_wr),
    .rd_idx (hs_r[HW-1:0]),
    .rd_rec (host_rd),
    .valid  (host_valid)
  );

  hbh_route_table #(
    .NUM_HOSTS        (NUM_HOSTS),
    .ENTRIES_PER_HOST (ENTRIES_PER_HOST)
  ) u_route (
    .clk     (clk),
    .wr_en   (route_we),
    .wr_addr (route_waddr),
    .wr_data (route_wr),
    .rd_addr (route_raddr),
    .rd_data (route_rd)
  );

  assign host_hit = hq_vld_r && host_valid[hq_tag_r] && (host_rd.ip == cur_r);
  assign host_end = hq_vld_r && (host_hit || (32'(hq_tag_r) == NUM_HOSTS - 1));

  assign better   = rq_vld_r && ((dst_r & route_rd.mask) == route_rd.subnet) &&
                    (!best_vld_r || (route_rd.mask > best_mask_r));
  assign fin_vld  = best_vld_r || better;
  assign fin_next = better ? route_rd.next_hop : best_next_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    dst_r       <= dst_nxt;
    hop_r       <= hop_nxt;
    hs_r        <= hs_nxt;
    hq_vld_r    <= hq_vld_nxt;
    hq_tag_r    <= hq_tag_nxt;
    h_r         <= h_nxt;
    cnt_r       <= cnt_nxt;
    ep_r        <= ep_nxt;
    rq_vld_r    <= rq_vld_nxt;
    rq_tag_r    <= rq_tag_nxt;
    best_vld_r  <= best_vld_nxt;
    best_mask_r <= best_mask_nxt;
    best_next_r <= best_next_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    dst_nxt       = dst_r;
    hop_nxt       = hop_r;
    hs_nxt        = hs_r;
    hq_vld_nxt    = hq_vld_r;
    hq_tag_nxt    = hq_tag_r;
    h_nxt         = h_r;
    cnt_nxt       = cnt_r;
    ep_nxt        = ep_r;
    rq_vld_nxt    = rq_vld_r;
    rq_tag_nxt    = rq_tag_r;
    best_vld_nxt  = best_vld_r;
    best_mask_nxt = best_mask_r;
    best_next_nxt = best_next_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (accept && (in_item.kind == KIND_QUERY) &&
            (in_item.origin_ip != 32'h0) && (in_item.dest_ip != 32'h0)) begin
          cur_nxt   = in_item.origin_ip;
          dst_nxt   = in_item.dest_ip;
          hop_nxt   = '0;
          state_nxt = S_HOP;
        end
      end
      S_HOP: begin
        if (cur_r == 32'h0) begin
          out_valid_nxt = 1'b1;
          out_nxt       = mk_out(32'h0, 3'd0, ST_NET, 1'b1);
          state_nxt     = S_IDLE;
        end else begin
          hs_nxt     = '0;
          hq_vld_nxt = 1'b0;
          state_nxt  = S_HSCAN;
        end
      end
      S_HSCAN: begin
        hq_vld_nxt = (hs_r < HCW'(NUM_HOSTS));
        hq_tag_nxt = hs_r[HW-1:0];
        if (hs_r < HCW'(NUM_HOSTS)) begin
          hs_nxt = HCW'(hs_r + 1'b1);
        end
        if (host_end) begin
          if (cur_r == dst_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = host_hit ? mk_out(cur_r, 3'(hq_tag_r), ST_DEST, 1'b1)
                                     : mk_out(cur_r, 3'd0, ST_UNKNOWN, 1'b1);
            state_nxt     = S_IDLE;
          end else if (!host_hit) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(cur_r, 3'd0, ST_UNKNOWN, 1'b1);
            state_nxt     = S_IDLE;
          end else if (host_rd.count == 5'd0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = mk_out(cur_r, 3'(hq_tag_r), ST_NOROUTE, 1'b1);
            state_nxt     = S_IDLE;
          end else begin
            h_nxt        = hq_tag_r;
            cnt_nxt      = host_rd.count;
            ep_nxt       = '0;
            rq_vld_nxt   = 1'b0;
            best_vld_nxt = 1'b0;
            state_nxt    = S_RSCAN;
          end
        end
      end
      S_RSCAN: begin
        rq_vld_nxt = (ep_r < cnt_r);
        rq_tag_nxt = ep_r;
        if (ep_r < cnt_r) begin
          ep_nxt = ep_r + 5'd1;
        end
        if (better) begin
          best_vld_nxt  = 1'b1;
          best_mask_nxt = route_rd.mask;
          best_next_nxt = route_rd.next_hop;
        end
        if (rq_vld_r && (rq_tag_r == cnt_r - 5'd1)) begin
          out_valid_nxt = 1'b1;
          if (!fin_vld) begin
            out_nxt   = mk_out(cur_r, 3'(h_r), ST_NOROUTE, 1'b1);
            state_nxt = S_IDLE;
          end else if (32'(hop_r) == MAX_HOPS - 1) begin
            out_nxt   = mk_out(cur_r, 3'(h_r), ST_LIMIT, 1'b1);
            state_nxt = S_IDLE;
          end else begin
            out_nxt   = mk_out(cur_r, 3'(h_r), ST_HOP, 1'b0);
            cur_nxt   = fin_next;
            hop_nxt   = KW'(hop_r + 1'b1);
            state_nxt = S_HOP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTH
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.last |-> state_r == S_IDLE)
    else $error("final beat while walk still active");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> state_r == S_HOP)
    else $error("intermediate beat without next hop");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !out_valid_r)
    else $error("result beat right after accept");

  a_limit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_LIMIT) |-> out_r.last)
    else $error("hop limit beat not final");

  a_hop_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.status == ST_HOP)
    else $error("non-final beat with terminal status");
`endif

endmodule
